FILE: rtl/sqg_pkg.sv
// Package for the single-qubit gate unit: gate opcodes, register map and
// fixed-point helpers. No dependencies.
package sqg_pkg;

    localparam int AMP_BITS_DEF = 16;
    localparam int OPCODE_W     = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;

    // register indexes, decoded from paddr[2]
    localparam logic REG_PHASE_RE = 1'b0;
    localparam logic REG_PHASE_IM = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ID    = 4'd0,
        OP_H     = 4'd1,
        OP_X     = 4'd2,
        OP_Y     = 4'd3,
        OP_Z     = 4'd4,
        OP_S     = 4'd5,
        OP_SDG   = 4'd6,
        OP_T     = 4'd7,
        OP_PROJ0 = 4'd8,
        OP_PROJ1 = 4'd9,
        OP_PHASE = 4'd10
    } op_t;

    // round(2^f / sqrt(2)) = round(sqrt(2^(2f-1))), elaboration time only
    function automatic longint unsigned inv_sqrt2(input int f);
        longint unsigned n;
        longint unsigned rem;
        longint unsigned r;
        longint unsigned b;
        n   = 64'd1 << (2 * f - 1);
        rem = n;
        r   = 64'd0;
        b   = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (r * r + r < n)
        begin
            r = r + 64'd1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/single_qubit_gate_apply_core.sv
// Top level of the single-qubit gate unit: 2x2 complex gate on an amplitude
// pair, four-stage pipeline, APB phase registers. Depends on sqg_pkg.

// Takes one request (opcode plus amplitudes a0, a1) per cycle when not stalled and
// returns b0, b1 via decode/operand select, multiply, two-term add with rounding
// bias, then shift and saturate into the output register. Every gate is mapped
// onto the same eight signed multipliers (AMP_BITS by AMP_BITS+1), so throughput
// is one request per cycle whatever the opcode mix while the output is not stalled;
// back-pressure stalls only full stages. Phase registers: byte 0 real, 4 imaginary,
// Q1.(AMP_BITS-1); the user must write them only while the unit is idle (unchecked).
module single_qubit_gate_apply_core
    import sqg_pkg::*;
#(
    parameter int AMP_BITS = AMP_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // APB configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [CFG_ADDR_W-1:0]      paddr,
    input  logic [CFG_DATA_W-1:0]      pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready,
    // request channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OPCODE_W-1:0]        opcode,
    input  logic signed [AMP_BITS-1:0] a0_re,
    input  logic signed [AMP_BITS-1:0] a0_im,
    input  logic signed [AMP_BITS-1:0] a1_re,
    input  logic signed [AMP_BITS-1:0] a1_im,
    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [AMP_BITS-1:0] b0_re,
    output logic signed [AMP_BITS-1:0] b0_im,
    output logic signed [AMP_BITS-1:0] b1_re,
    output logic signed [AMP_BITS-1:0] b1_im
);

    localparam int F     = AMP_BITS - 1;
    localparam int AW    = AMP_BITS;
    localparam int YW    = AMP_BITS + 1;
    localparam int PW    = AW + YW;
    localparam int SW    = PW + 1;
    localparam int LANES = 4;

    localparam logic signed [YW-1:0] Y_ONE  = YW'(longint'(1) << F);
    localparam logic signed [YW-1:0] Y_NEG  = -Y_ONE;
    localparam logic signed [YW-1:0] Y_C    = YW'(inv_sqrt2(F));
    localparam logic signed [YW-1:0] Y_NC   = -Y_C;
    localparam logic signed [SW-1:0] HALF   = SW'(longint'(1) << (F - 1));
    localparam logic signed [SW-1:0] SAT_HI = SW'((longint'(1) << F) - 1);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(longint'(1) << F);

    // ---------------- configuration ----------------
    logic signed [AW-1:0] phase_re_reg;
    logic signed [AW-1:0] phase_im_reg;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_re_reg <= AW'((longint'(1) << F) - 1);
            phase_im_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_PHASE_RE)
            begin
                phase_re_reg <= pwdata[AW-1:0];
            end
            else
            begin
                phase_im_reg <= pwdata[AW-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_PHASE_IM)
        begin
            prdata = CFG_DATA_W'($unsigned(phase_im_reg));
        end
        else
        begin
            prdata = CFG_DATA_W'($unsigned(phase_re_reg));
        end
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ---------------- stage 1: operand select ----------------
    // lane order: b0_re, b0_im, b1_re, b1_im; each lane is x1*y1 + x2*y2
    logic signed [AW-1:0] x1_next [LANES];
    logic signed [YW-1:0] y1_next [LANES];
    logic signed [AW-1:0] x2_next [LANES];
    logic signed [YW-1:0] y2_next [LANES];
    logic signed [YW-1:0] pr_ext, pi_ext;

    assign pr_ext = YW'(phase_re_reg);
    assign pi_ext = YW'(phase_im_reg);

    always_comb
    begin
        // identity by default; plain moves and negations use a +/-1.0 factor
        x1_next[0] = a0_re;  y1_next[0] = Y_ONE;
        x1_next[1] = a0_im;  y1_next[1] = Y_ONE;
        x1_next[2] = a1_re;  y1_next[2] = Y_ONE;
        x1_next[3] = a1_im;  y1_next[3] = Y_ONE;
        for (int i = 0; i < LANES; i++)
        begin
            x2_next[i] = '0;
            y2_next[i] = '0;
        end
        unique case (op_t'(opcode))
            OP_ID:
            begin
            end
            OP_H:
            begin
                x1_next[0] = a0_re;  y1_next[0] = Y_C;  x2_next[0] = a1_re;  y2_next[0] = Y_C;
                x1_next[1] = a0_im;  y1_next[1] = Y_C;  x2_next[1] = a1_im;  y2_next[1] = Y_C;
                x1_next[2] = a0_re;  y1_next[2] = Y_C;  x2_next[2] = a1_re;  y2_next[2] = Y_NC;
                x1_next[3] = a0_im;  y1_next[3] = Y_C;  x2_next[3] = a1_im;  y2_next[3] = Y_NC;
            end
            OP_X:
            begin
                x1_next[0] = a1_re;
                x1_next[1] = a1_im;
                x1_next[2] = a0_re;
                x1_next[3] = a0_im;
            end
            OP_Y:
            begin
                x1_next[0] = a1_im;
                x1_next[1] = a1_re;  y1_next[1] = Y_NEG;
                x1_next[2] = a0_im;  y1_next[2] = Y_NEG;
                x1_next[3] = a0_re;
            end
            OP_Z:
            begin
                y1_next[2] = Y_NEG;
                y1_next[3] = Y_NEG;
            end
            OP_S:
            begin
                x1_next[2] = a1_im;  y1_next[2] = Y_NEG;
                x1_next[3] = a1_re;
            end
            OP_SDG:
            begin
                x1_next[2] = a1_im;
                x1_next[3] = a1_re;  y1_next[3] = Y_NEG;
            end
            OP_T:
            begin
                x1_next[2] = a1_re;  y1_next[2] = Y_C;  x2_next[2] = a1_im;  y2_next[2] = Y_NC;
                x1_next[3] = a1_re;  y1_next[3] = Y_C;  x2_next[3] = a1_im;  y2_next[3] = Y_C;
            end
            OP_PROJ0:
            begin
                x1_next[2] = '0;
                x1_next[3] = '0;
            end
            OP_PROJ1:
            begin
                x1_next[0] = '0;
                x1_next[1] = '0;
            end
            OP_PHASE:
            begin
                x1_next[2] = a1_re;  y1_next[2] = pr_ext;
                x2_next[2] = a1_im;  y2_next[2] = -pi_ext;
                x1_next[3] = a1_re;  y1_next[3] = pi_ext;
                x2_next[3] = a1_im;  y2_next[3] = pr_ext;
            end
            default:
            begin
                // unused opcodes pass the pair through
            end
        endcase
    end

    logic signed [AW-1:0] s1_x1_reg [LANES];
    logic signed [YW-1:0] s1_y1_reg [LANES];
    logic signed [AW-1:0] s1_x2_reg [LANES];
    logic signed [YW-1:0] s1_y2_reg [LANES];
    logic signed [PW-1:0] s2_p1_reg [LANES];
    logic signed [PW-1:0] s2_p2_reg [LANES];
    logic signed [SW-1:0] s3_sum_reg [LANES];
    logic signed [AW-1:0] s4_out_reg [LANES];

    logic signed [SW-1:0] shifted [LANES];
    logic signed [AW-1:0] sat_next [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            shifted[i] = s3_sum_reg[i] >>> F;
            if (shifted[i] > SAT_HI)
            begin
                sat_next[i] = SAT_HI[AW-1:0];
            end
            else if (shifted[i] < SAT_LO)
            begin
                sat_next[i] = SAT_LO[AW-1:0];
            end
            else
            begin
                sat_next[i] = shifted[i][AW-1:0];
            end
        end
    end

    // payload: stage 1 select, stage 2 multiply, stage 3 add + bias, stage 4 saturate
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (s1_ready)
            begin
                s1_x1_reg[i] <= x1_next[i];
                s1_y1_reg[i] <= y1_next[i];
                s1_x2_reg[i] <= x2_next[i];
                s1_y2_reg[i] <= y2_next[i];
            end
            if (s2_ready)
            begin
                s2_p1_reg[i] <= s1_x1_reg[i] * s1_y1_reg[i];
                s2_p2_reg[i] <= s1_x2_reg[i] * s1_y2_reg[i];
            end
            if (s3_ready)
            begin
                s3_sum_reg[i] <= SW'(s2_p1_reg[i]) + SW'(s2_p2_reg[i]) + HALF;
            end
            if (s4_ready)
            begin
                s4_out_reg[i] <= sat_next[i];
            end
        end
    end

    assign out_valid = s4_valid_reg;
    assign b0_re     = s4_out_reg[0];
    assign b0_im     = s4_out_reg[1];
    assign b1_re     = s4_out_reg[2];
    assign b1_im     = s4_out_reg[3];

    // ---------------- assertions ----------------
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted request did not enter stage 1");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> s2_valid_reg)
        else $error("stalled stage 2 request was dropped");

    a_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s4_ready |=> out_valid)
        else $error("stage 3 request did not reach the output register");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && !out_ready
        |-> !in_ready)
        else $error("request taken while pipeline is full and stalled");

endmodule

FILE: verif/tb.sv
// Testbench for single_qubit_gate_apply_core: random and directed gate requests
// checked against a built-in predictor, with phase register writes between phases.
// Depends on sqg_pkg and the core RTL.
import sqg_pkg::*;

typedef logic signed [AMP_BITS_DEF-1:0] amp_t;

typedef struct packed {
    amp_t s0_re;
    amp_t s0_im;
    amp_t s1_re;
    amp_t s1_im;
} amp_pair_t;

localparam int   FRAC_BITS  = AMP_BITS_DEF - 1;
localparam amp_t AMP_MAX    = {1'b0, {(AMP_BITS_DEF-1){1'b1}}};
localparam amp_t AMP_MIN    = {1'b1, {(AMP_BITS_DEF-1){1'b0}}};
// round(2^15 / sqrt(2))
localparam longint INV_SQRT2  = 23170;
localparam longint ROUND_HALF = longint'(1) << (FRAC_BITS - 1);

class amp_pair_checker;
    amp_t      phase_re;
    amp_t      phase_im;
    amp_pair_t expected_pairs[$];
    int        mismatches;

    function new();
        phase_re   = AMP_MAX;
        phase_im   = '0;
        mismatches = 0;
    endfunction

    function void set_phase(amp_t re, amp_t im);
        phase_re = re;
        phase_im = im;
    endfunction

    function int pending();
        return expected_pairs.size();
    endfunction

    task report_mismatch(string msg);
        $display("mismatch @%0t: %s", $time, msg);
        mismatches++;
    endtask

    function amp_t clamp(longint v);
        if (v > longint'(AMP_MAX))
            return AMP_MAX;
        if (v < longint'(AMP_MIN))
            return AMP_MIN;
        return amp_t'(v);
    endfunction

    // (x1*y1 + x2*y2) / 2^F, round half up, saturated
    function amp_t round_mac(longint x1, longint y1, longint x2, longint y2);
        longint acc;
        acc = x1 * y1 + x2 * y2 + ROUND_HALF;
        return clamp(acc >>> FRAC_BITS);
    endfunction

    function amp_t negate(amp_t v);
        return clamp(-longint'($signed(v)));
    endfunction

    function amp_pair_t apply_gate(logic [OPCODE_W-1:0] op, amp_pair_t a);
        longint    r0;
        longint    i0;
        longint    r1;
        longint    i1;
        longint    pr;
        longint    pim;
        amp_pair_t q;
        r0  = $signed(a.s0_re);
        i0  = $signed(a.s0_im);
        r1  = $signed(a.s1_re);
        i1  = $signed(a.s1_im);
        pr  = $signed(phase_re);
        pim = $signed(phase_im);
        q   = a;
        case (op)
            OP_H:
            begin
                q.s0_re = round_mac(r0, INV_SQRT2, r1, INV_SQRT2);
                q.s0_im = round_mac(i0, INV_SQRT2, i1, INV_SQRT2);
                q.s1_re = round_mac(r0, INV_SQRT2, r1, -INV_SQRT2);
                q.s1_im = round_mac(i0, INV_SQRT2, i1, -INV_SQRT2);
            end
            OP_X:
            begin
                q.s0_re = a.s1_re;
                q.s0_im = a.s1_im;
                q.s1_re = a.s0_re;
                q.s1_im = a.s0_im;
            end
            OP_Y:
            begin
                q.s0_re = a.s1_im;
                q.s0_im = negate(a.s1_re);
                q.s1_re = negate(a.s0_im);
                q.s1_im = a.s0_re;
            end
            OP_Z:
            begin
                q.s1_re = negate(a.s1_re);
                q.s1_im = negate(a.s1_im);
            end
            OP_S:
            begin
                q.s1_re = negate(a.s1_im);
                q.s1_im = a.s1_re;
            end
            OP_SDG:
            begin
                q.s1_re = a.s1_im;
                q.s1_im = negate(a.s1_re);
            end
            OP_T:
            begin
                q.s1_re = round_mac(r1, INV_SQRT2, i1, -INV_SQRT2);
                q.s1_im = round_mac(r1, INV_SQRT2, i1, INV_SQRT2);
            end
            OP_PROJ0:
            begin
                q.s1_re = '0;
                q.s1_im = '0;
            end
            OP_PROJ1:
            begin
                q.s0_re = '0;
                q.s0_im = '0;
            end
            OP_PHASE:
            begin
                q.s1_re = round_mac(r1, pr, i1, -pim);
                q.s1_im = round_mac(r1, pim, i1, pr);
            end
            default:
            begin
                // unused codes pass the pair through
            end
        endcase
        return q;
    endfunction

    function void note_request(logic [OPCODE_W-1:0] op, amp_pair_t a);
        expected_pairs.insert(expected_pairs.size(), apply_gate(op, a));
    endfunction

    task compare_field(string name, amp_t got, amp_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(amp_pair_t got);
        amp_pair_t want;
        if (expected_pairs.size() == 0)
        begin
            report_mismatch("result with no request outstanding");
            return;
        end
        want = expected_pairs.pop_front();
        compare_field("b0_re", got.s0_re, want.s0_re);
        compare_field("b0_im", got.s0_im, want.s0_im);
        compare_field("b1_re", got.s1_re, want.s1_re);
        compare_field("b1_im", got.s1_im, want.s1_im);
    endtask
endclass

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 8;
    localparam int ITEMS_PER_PHASE = 144;
    localparam int OP_CODES       = 1 << OPCODE_W;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic [OPCODE_W-1:0]   opcode;
    amp_t                  a0_re;
    amp_t                  a0_im;
    amp_t                  a1_re;
    amp_t                  a1_im;
    logic                  out_valid;
    logic                  out_ready;
    amp_t                  b0_re;
    amp_t                  b0_im;
    amp_t                  b1_re;
    amp_t                  b1_im;

    amp_pair_checker sb;
    bit              tx_burst;
    bit              rx_burst;
    int              rx_hold;
    int              idle_cycles;

    single_qubit_gate_apply_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .a0_re     (a0_re),
        .a0_im     (a0_im),
        .a1_re     (a1_re),
        .a1_im     (a1_im),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .b0_re     (b0_re),
        .b0_im     (b0_im),
        .b1_re     (b1_re),
        .b1_im     (b1_im)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // result side: random stall before each result, with stall-free stretches
    always @(negedge clk)
    begin
        out_ready <= (rx_hold == 0);
        if (rx_hold != 0)
            rx_hold--;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result('{b0_re, b0_im, b1_re, b1_im});
            if ($urandom_range(0, 29) == 0)
                rx_burst = !rx_burst;
            rx_hold = rx_burst ? 0 : $urandom_range(0, 19);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic amp_t rand_amp();
        amp_t v;
        case ($urandom_range(0, 9))
            0: v = AMP_MIN;
            1: v = AMP_MAX;
            2: v = '0;
            3: v = amp_t'(int'($urandom_range(0, 64)) - 32);
            default: v = amp_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_request(logic [OPCODE_W-1:0] op, amp_pair_t a);
        int gap;
        if ($urandom_range(0, 29) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        a0_re    <= a.s0_re;
        a0_im    <= a.s0_im;
        a1_re    <= a.s1_re;
        a1_im    <= a.s1_im;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(op, a);
    endtask

    task automatic send_random_request();
        logic [OPCODE_W-1:0] op;
        // mostly real gates, a few unused codes
        if ($urandom_range(0, 19) < 18)
            op = OPCODE_W'($urandom_range(OP_ID, OP_PHASE));
        else
            op = OPCODE_W'($urandom_range(OP_PHASE + 1, OP_CODES - 1));
        send_request(op, '{rand_amp(), rand_amp(), rand_amp(), rand_amp()});
    endtask

    task automatic pause_requests();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(logic wr, logic idx, logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_phase_regs();
        logic [CFG_DATA_W-1:0] rd;
        apb_access(1'b0, REG_PHASE_RE, '0, rd);
        if (amp_t'(rd) !== sb.phase_re)
            sb.report_mismatch($sformatf("phase_re read %0d", amp_t'(rd)));
        apb_access(1'b0, REG_PHASE_IM, '0, rd);
        if (amp_t'(rd) !== sb.phase_im)
            sb.report_mismatch($sformatf("phase_im read %0d", amp_t'(rd)));
    endtask

    task automatic program_phase(amp_t re, amp_t im);
        logic [CFG_DATA_W-1:0] rd;
        // upper bits are junk; only the low AMP_BITS are kept
        apb_access(1'b1, REG_PHASE_RE, {16'($urandom), re}, rd);
        apb_access(1'b1, REG_PHASE_IM, {16'($urandom), im}, rd);
        sb.set_phase(re, im);
        check_phase_regs();
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        opcode      = OP_ID;
        a0_re       = '0;
        a0_im       = '0;
        a1_re       = '0;
        a1_im       = '0;
        out_ready   = 1'b0;
        rx_hold     = 0;
        idle_cycles = 0;
        tx_burst    = 1'b0;
        rx_burst    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        check_phase_regs();

        // every code with opposite extremes in each part
        for (int k = 0; k < OP_CODES; k++)
            send_request(OPCODE_W'(k), '{AMP_MIN, AMP_MAX, AMP_MIN, AMP_MAX});
        send_request(OP_H, '{AMP_MAX, AMP_MAX, AMP_MAX, AMP_MAX});
        send_request(OP_H, '{AMP_MIN, AMP_MIN, AMP_MIN, AMP_MIN});
        // exact half-LSB products: ties round up
        send_request(OP_H, '{16'sd8192, -16'sd8192, '0, '0});
        send_request(OP_T, '{'0, '0, 16'sd8192, -16'sd8192});
        send_request(OP_T, '{'0, '0, AMP_MIN, AMP_MAX});
        send_request(OP_PHASE, '{AMP_MAX, AMP_MIN, AMP_MIN, AMP_MIN});
        send_request(OP_Z, '{AMP_MAX, AMP_MAX, AMP_MIN, AMP_MIN});
        send_request(OP_Y, '{AMP_MIN, AMP_MIN, AMP_MIN, AMP_MIN});
        pause_requests();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: ;  // run on reset values first
                1: program_phase(AMP_MIN, AMP_MIN);
                2: program_phase(AMP_MAX, AMP_MAX);
                3: program_phase('0, AMP_MIN);
                4: program_phase(AMP_MIN, AMP_MAX);
                5: program_phase(amp_t'(INV_SQRT2), amp_t'(INV_SQRT2));
                default: program_phase(amp_t'($urandom), amp_t'($urandom));
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 2 && i == ITEMS_PER_PHASE / 2)
                    pause_requests();
                send_random_request();
            end
            pause_requests();
        end

        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
